### hdl/acmc_pkg.sv
// ----------------------------------------------------------------------------
// acmc_pkg
// shared constants for the alarm clock mode controller
// ----------------------------------------------------------------------------
package acmc_pkg;

    // configuration register indexes
    localparam logic [0:0] REG_PERIODS_PER_STEP = 1'd0;
    localparam logic [0:0] REG_PRESS_LIMIT      = 1'd1;

    // configuration reset values
    localparam logic [3:0] PERIODS_PER_STEP_RST = 4'd2;
    localparam logic [2:0] PRESS_LIMIT_RST      = 3'd4;

    // time keeping limits
    localparam logic [5:0] SEC_WRAP  = 6'd60;
    localparam logic [5:0] MIN_WRAP  = 6'd60;
    localparam logic [4:0] HOUR_WRAP = 5'd24;

    // alarm reset setting
    localparam logic [4:0] ALARM_HOUR_RST   = 5'd1;
    localparam logic [5:0] ALARM_MINUTE_RST = 6'd1;

    // press counter saturation value
    localparam logic [2:0] PRESS_SAT = 3'd7;

    // led bit positions in the active-low indicator vector
    localparam int LED_TIME_SET  = 0;
    localparam int LED_ALARM_SET = 1;
    localparam int LED_RING      = 2;

endpackage

### hdl/alarm_clock_mode_controller.sv
// ----------------------------------------------------------------------------
// alarm_clock_mode_controller
// latency: a result is presented the cycle after its input transaction
// throughput: one transaction per cycle while m_ready is high, set by the
//   single update stage of the clock/mode registers, which are the result register
// reset: aresetn synchronous active low, clears time, mode and counters,
//   alarm to 01:01, leds off (high), config to 2 periods and a limit of 4
// ----------------------------------------------------------------------------
module alarm_clock_mode_controller (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration writes
    input  logic       cfg_we,
    input  logic [0:0] cfg_addr,
    input  logic [3:0] cfg_wdata,
    // timer period input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_set_time_pressed,
    input  logic       s_set_alarm_pressed,
    input  logic       s_snooze_pressed,
    input  logic [9:0] s_adc_sample,
    // result
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_hours,
    output logic [5:0] m_minutes,
    output logic [5:0] m_seconds,
    output logic [4:0] m_alarm_hours,
    output logic [5:0] m_alarm_minutes,
    output logic [1:0] m_mode,
    output logic       m_alarm_enabled,
    output logic       m_ring_led,
    output logic       m_time_set_led,
    output logic       m_alarm_set_led,
    output logic       m_step_done
);

    typedef enum logic [1:0] {
        MODE_RUN       = 2'd0,
        MODE_SET_TIME  = 2'd1,
        MODE_SET_ALARM = 2'd2,
        MODE_RING      = 2'd3
    } mode_t;

    // configuration
    logic [3:0]  periods_per_step_reg;
    logic [2:0]  press_limit_reg;

    // clock state; these registers are also the visible result
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [4:0]  alarm_hour_reg, alarm_hour_next;
    logic [5:0]  alarm_minute_reg, alarm_minute_next;
    mode_t       mode_reg, mode_next;
    logic        armed_reg, armed_next;
    logic        held_reg, held_next;
    logic [2:0]  time_cnt_reg, time_cnt_next;
    logic [2:0]  alarm_cnt_reg, alarm_cnt_next;
    logic [3:0]  period_reg, period_next;
    logic        chan_reg, chan_next;
    logic [2:0]  led_reg, led_next;
    logic        step_reg, step_next;
    logic        valid_reg;

    logic        in_accept;

    // sample scaling: x*24>>10 == x*3>>7, x*60>>10 == x*15>>8
    logic [11:0] sample_x3;
    logic [13:0] sample_x15;
    logic [4:0]  sample_hours;
    logic [5:0]  sample_minutes;

    // result is held in the state registers, so new work only when it is free
    assign s_ready   = !valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    assign sample_x3      = {2'b00, s_adc_sample} + {1'b0, s_adc_sample, 1'b0};
    assign sample_x15     = {s_adc_sample, 4'b0000} - {4'b0000, s_adc_sample};
    assign sample_hours   = sample_x3[11:7];
    assign sample_minutes = sample_x15[13:8];

    // next-state logic for one timer period, written in the order of events
    always_comb begin
        logic step;
        logic hit;

        hour_next         = hour_reg;
        minute_next       = minute_reg;
        second_next       = second_reg;
        alarm_hour_next   = alarm_hour_reg;
        alarm_minute_next = alarm_minute_reg;
        mode_next         = mode_reg;
        armed_next        = armed_reg;
        held_next         = held_reg;
        time_cnt_next     = time_cnt_reg;
        alarm_cnt_next    = alarm_cnt_reg;
        period_next       = period_reg;
        chan_next         = chan_reg;
        led_next          = led_reg;
        step              = 1'b0;
        hit               = 1'b0;

        if (mode_reg == MODE_RING) begin
            // every period is a step while ringing
            period_next = '0;
            step        = 1'b1;
        end else begin
            period_next = period_reg + 4'd1;
            if (s_set_time_pressed && time_cnt_reg < acmc_pkg::PRESS_SAT) begin
                time_cnt_next = time_cnt_reg + 3'd1;
            end
            if (s_set_alarm_pressed && alarm_cnt_reg < acmc_pkg::PRESS_SAT) begin
                alarm_cnt_next = alarm_cnt_reg + 3'd1;
            end
            // long press enters a set mode at once; time button wins
            if (time_cnt_next >= press_limit_reg) begin
                time_cnt_next = '0;
                held_next     = 1'b1;
                mode_next     = MODE_SET_TIME;
                step          = 1'b1;
            end else if (alarm_cnt_next >= press_limit_reg) begin
                alarm_cnt_next = '0;
                held_next      = 1'b1;
                mode_next      = MODE_SET_ALARM;
                step           = 1'b1;
            end
            // a zero period setting behaves as one
            if (period_next >= periods_per_step_reg) begin
                step = 1'b1;
            end
            if (step) begin
                period_next = '0;
            end
        end

        // the step acts on the mode that was active at the start of the period
        if (step) begin
            unique case (mode_reg)
                MODE_RUN: begin
                    second_next = second_reg + 6'd1;
                    if (second_next >= acmc_pkg::SEC_WRAP) begin
                        second_next = '0;
                        minute_next = minute_reg + 6'd1;
                    end
                    if (minute_next >= acmc_pkg::MIN_WRAP) begin
                        minute_next = '0;
                        hour_next   = hour_reg + 5'd1;
                    end
                    if (hour_next >= acmc_pkg::HOUR_WRAP) begin
                        hour_next = '0;
                    end
                    if (armed_reg && hour_next == alarm_hour_reg &&
                        minute_next == alarm_minute_reg) begin
                        mode_next = MODE_RING;
                    end
                    // snooze edge toggles the alarm arm
                    if (s_snooze_pressed && !held_next) begin
                        held_next  = 1'b1;
                        armed_next = !armed_reg;
                    end else if (!s_snooze_pressed && held_next) begin
                        held_next = 1'b0;
                    end
                end
                MODE_SET_TIME: begin
                    led_next[acmc_pkg::LED_TIME_SET] = 1'b0;
                    chan_next = !chan_reg;
                    if (chan_next) begin
                        hour_next = sample_hours;
                    end else begin
                        minute_next = sample_minutes;
                    end
                    if (s_set_time_pressed && !held_next) begin
                        held_next = 1'b1;
                        hit       = 1'b1;
                    end else if (!s_set_time_pressed && held_next) begin
                        held_next = 1'b0;
                    end
                    if (hit) begin
                        led_next[acmc_pkg::LED_TIME_SET] = 1'b1;
                        mode_next = MODE_RUN;
                    end
                end
                MODE_SET_ALARM: begin
                    led_next[acmc_pkg::LED_ALARM_SET] = 1'b0;
                    chan_next = !chan_reg;
                    if (chan_next) begin
                        alarm_hour_next = sample_hours;
                    end else begin
                        alarm_minute_next = sample_minutes;
                    end
                    if (s_set_alarm_pressed && !held_next) begin
                        held_next = 1'b1;
                        hit       = 1'b1;
                    end else if (!s_set_alarm_pressed && held_next) begin
                        held_next = 1'b0;
                    end
                    if (hit) begin
                        led_next[acmc_pkg::LED_ALARM_SET] = 1'b1;
                        mode_next = MODE_RUN;
                    end
                end
                MODE_RING: begin
                    led_next[acmc_pkg::LED_RING] = 1'b0;
                    if (s_snooze_pressed && !held_next) begin
                        held_next = 1'b1;
                        hit       = 1'b1;
                    end else if (!s_snooze_pressed && held_next) begin
                        held_next = 1'b0;
                    end
                    if (hit) begin
                        led_next[acmc_pkg::LED_RING] = 1'b1;
                        armed_next = !armed_reg;
                        mode_next  = MODE_RUN;
                    end
                end
                default: begin
                    mode_next = MODE_RUN;
                end
            endcase
        end

        step_next = step;
    end

    // configuration registers; write only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            periods_per_step_reg <= acmc_pkg::PERIODS_PER_STEP_RST;
            press_limit_reg      <= acmc_pkg::PRESS_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                acmc_pkg::REG_PERIODS_PER_STEP: periods_per_step_reg <= cfg_wdata;
                acmc_pkg::REG_PRESS_LIMIT:      press_limit_reg      <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // state and result registers, updated once per accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_reg         <= '0;
            minute_reg       <= '0;
            second_reg       <= '0;
            alarm_hour_reg   <= acmc_pkg::ALARM_HOUR_RST;
            alarm_minute_reg <= acmc_pkg::ALARM_MINUTE_RST;
            mode_reg         <= MODE_RUN;
            armed_reg        <= 1'b0;
            held_reg         <= 1'b0;
            time_cnt_reg     <= '0;
            alarm_cnt_reg    <= '0;
            period_reg       <= '0;
            chan_reg         <= 1'b0;
            led_reg          <= '1;
            step_reg         <= 1'b0;
            valid_reg        <= 1'b0;
        end else begin
            if (in_accept) begin
                hour_reg         <= hour_next;
                minute_reg       <= minute_next;
                second_reg       <= second_next;
                alarm_hour_reg   <= alarm_hour_next;
                alarm_minute_reg <= alarm_minute_next;
                mode_reg         <= mode_next;
                armed_reg        <= armed_next;
                held_reg         <= held_next;
                time_cnt_reg     <= time_cnt_next;
                alarm_cnt_reg    <= alarm_cnt_next;
                period_reg       <= period_next;
                chan_reg         <= chan_next;
                led_reg          <= led_next;
                step_reg         <= step_next;
                valid_reg        <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // result fields come straight from the state registers
    assign m_valid         = valid_reg;
    assign m_hours         = hour_reg;
    assign m_minutes       = minute_reg;
    assign m_seconds       = second_reg;
    assign m_alarm_hours   = alarm_hour_reg;
    assign m_alarm_minutes = alarm_minute_reg;
    assign m_mode          = mode_reg;
    assign m_alarm_enabled = armed_reg;
    assign m_ring_led      = led_reg[acmc_pkg::LED_RING];
    assign m_time_set_led  = led_reg[acmc_pkg::LED_TIME_SET];
    assign m_alarm_set_led = led_reg[acmc_pkg::LED_ALARM_SET];
    assign m_step_done     = step_reg;

    // time of day stays in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        second_reg < acmc_pkg::SEC_WRAP && minute_reg < acmc_pkg::MIN_WRAP &&
        hour_reg < acmc_pkg::HOUR_WRAP)
        else $error("clock value out of range");

    // state moves only on an accepted transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_accept |=> $stable(hour_reg) && $stable(minute_reg) &&
        $stable(mode_reg) && $stable(period_reg))
        else $error("state changed without a transaction");

    // every ringing period is a step
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && mode_reg == MODE_RING |=> step_reg && period_reg == 4'd0)
        else $error("ringing period without a step");

    // a pending result is not overwritten while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !m_ready |-> !in_accept)
        else $error("result overwritten while stalled");

endmodule

### test/tb_alarm_clock_mode_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alarm_clock_mode_controller
// self-checking bench for the alarm clock mode controller: timer periods go
// in over a valid/ready channel, each result is compared with a cycle-free
// prediction of the clock, alarm, mode and indicator state
// ----------------------------------------------------------------------------
module tb_alarm_clock_mode_controller;

    // mode codes as seen on m_mode
    typedef enum logic [1:0] {
        MODE_RUN       = 2'd0,
        MODE_SET_TIME  = 2'd1,
        MODE_SET_ALARM = 2'd2,
        MODE_RINGING   = 2'd3
    } clock_mode_t;

    // which button a run of periods holds down
    typedef enum int {
        BTN_NONE,
        BTN_TIME,
        BTN_ALARM,
        BTN_SNOOZE
    } button_t;

    // one result transaction, field order matches the m_ ports
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [4:0] alarm_hours;
        logic [5:0] alarm_minutes;
        logic [1:0] mode;
        logic       alarm_enabled;
        logic       ring_led;
        logic       time_set_led;
        logic       alarm_set_led;
        logic       step_done;
    } clock_result_t;

    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_PERIODS = 200;

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic       aclk;
    logic       aresetn             = 1'b0;
    logic       cfg_we              = 1'b0;
    logic [0:0] cfg_addr            = acmc_pkg::REG_PERIODS_PER_STEP;
    logic [3:0] cfg_wdata           = 4'd0;
    logic       s_valid             = 1'b0;
    logic       s_ready;
    logic       s_set_time_pressed  = 1'b0;
    logic       s_set_alarm_pressed = 1'b0;
    logic       s_snooze_pressed    = 1'b0;
    logic [9:0] s_adc_sample        = 10'd0;
    logic       m_valid;
    logic       m_ready             = 1'b0;
    logic [4:0] m_hours;
    logic [5:0] m_minutes;
    logic [5:0] m_seconds;
    logic [4:0] m_alarm_hours;
    logic [5:0] m_alarm_minutes;
    logic [1:0] m_mode;
    logic       m_alarm_enabled;
    logic       m_ring_led;
    logic       m_time_set_led;
    logic       m_alarm_set_led;
    logic       m_step_done;

    alarm_clock_mode_controller u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_addr            (cfg_addr),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_set_time_pressed  (s_set_time_pressed),
        .s_set_alarm_pressed (s_set_alarm_pressed),
        .s_snooze_pressed    (s_snooze_pressed),
        .s_adc_sample        (s_adc_sample),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_hours             (m_hours),
        .m_minutes           (m_minutes),
        .m_seconds           (m_seconds),
        .m_alarm_hours       (m_alarm_hours),
        .m_alarm_minutes     (m_alarm_minutes),
        .m_mode              (m_mode),
        .m_alarm_enabled     (m_alarm_enabled),
        .m_ring_led          (m_ring_led),
        .m_time_set_led      (m_time_set_led),
        .m_alarm_set_led     (m_alarm_set_led),
        .m_step_done         (m_step_done)
    );

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // mirror of the clock state, updated on every accepted period
    // ------------------------------------------------------------------------
    logic [3:0]  steps_cfg;
    logic [2:0]  limit_cfg;
    logic [4:0]  hour_q;
    logic [5:0]  minute_q;
    logic [5:0]  second_q;
    logic [4:0]  alarm_hour_q;
    logic [5:0]  alarm_minute_q;
    clock_mode_t mode_q;
    logic        armed_q;
    logic        held_q;
    logic [2:0]  time_presses_q;
    logic [2:0]  alarm_presses_q;
    logic [3:0]  periods_q;
    logic        hour_channel_q;
    logic [2:0]  leds_q;

    clock_result_t clock_results_q[$];

    int n_mismatch   = 0;
    int n_sent       = 0;
    int burst_left   = 0;
    bit quiet_sender = 1'b0;

    task automatic reset_clock_mirror();
        steps_cfg       = acmc_pkg::PERIODS_PER_STEP_RST;
        limit_cfg       = acmc_pkg::PRESS_LIMIT_RST;
        hour_q          = '0;
        minute_q        = '0;
        second_q        = '0;
        alarm_hour_q    = acmc_pkg::ALARM_HOUR_RST;
        alarm_minute_q  = acmc_pkg::ALARM_MINUTE_RST;
        mode_q          = MODE_RUN;
        armed_q         = 1'b0;
        held_q          = 1'b0;
        time_presses_q  = '0;
        alarm_presses_q = '0;
        periods_q       = '0;
        hour_channel_q  = 1'b0;
        leds_q          = 3'b111;
    endtask

    // potentiometer scaling onto the hour and minute ranges
    function automatic logic [4:0] scaled_hours(logic [9:0] smp);
        int v;
        v = (int'(smp) * int'(acmc_pkg::HOUR_WRAP)) >> 10;
        return v[4:0];
    endfunction

    function automatic logic [5:0] scaled_minutes(logic [9:0] smp);
        int v;
        v = (int'(smp) * int'(acmc_pkg::MIN_WRAP)) >> 10;
        return v[5:0];
    endfunction

    // press edge on the shared held flag, release clears the flag
    function automatic logic held_edge(logic pressed);
        if (pressed && !held_q) begin
            held_q = 1'b1;
            return 1'b1;
        end
        if (!pressed && held_q)
            held_q = 1'b0;
        return 1'b0;
    endfunction

    function automatic clock_result_t advance_period(logic t_press, logic a_press,
                                                     logic s_press, logic [9:0] smp);
        clock_mode_t   body;
        logic          step;
        clock_result_t r;
        body = mode_q;
        step = 1'b0;

        if (body == MODE_RINGING) begin
            // ringing: every period is a step, press counters frozen
            periods_q = '0;
            step      = 1'b1;
        end else begin
            periods_q = periods_q + 4'd1;
            if (t_press && time_presses_q < acmc_pkg::PRESS_SAT)
                time_presses_q = time_presses_q + 3'd1;
            if (a_press && alarm_presses_q < acmc_pkg::PRESS_SAT)
                alarm_presses_q = alarm_presses_q + 3'd1;
            // early step into a set mode, time button wins
            if (time_presses_q >= limit_cfg) begin
                time_presses_q = '0;
                held_q         = 1'b1;
                mode_q         = MODE_SET_TIME;
                step           = 1'b1;
            end else if (alarm_presses_q >= limit_cfg) begin
                alarm_presses_q = '0;
                held_q          = 1'b1;
                mode_q          = MODE_SET_ALARM;
                step            = 1'b1;
            end
            // a zero setting behaves as one period per step
            if (periods_q >= steps_cfg)
                step = 1'b1;
            if (step)
                periods_q = '0;
        end

        // the step acts on the mode that was active before any change above
        if (step) begin
            case (body)
                MODE_RUN: begin
                    second_q = second_q + 6'd1;
                    if (second_q >= acmc_pkg::SEC_WRAP) begin
                        second_q = '0;
                        minute_q = minute_q + 6'd1;
                    end
                    if (minute_q >= acmc_pkg::MIN_WRAP) begin
                        minute_q = '0;
                        hour_q   = hour_q + 5'd1;
                    end
                    if (hour_q >= acmc_pkg::HOUR_WRAP)
                        hour_q = '0;
                    if (armed_q && hour_q == alarm_hour_q && minute_q == alarm_minute_q)
                        mode_q = MODE_RINGING;
                    if (held_edge(s_press))
                        armed_q = !armed_q;
                end
                MODE_SET_TIME: begin
                    leds_q[acmc_pkg::LED_TIME_SET] = 1'b0;
                    hour_channel_q = !hour_channel_q;
                    if (hour_channel_q)
                        hour_q = scaled_hours(smp);
                    else
                        minute_q = scaled_minutes(smp);
                    if (held_edge(t_press)) begin
                        leds_q[acmc_pkg::LED_TIME_SET] = 1'b1;
                        mode_q = MODE_RUN;
                    end
                end
                MODE_SET_ALARM: begin
                    leds_q[acmc_pkg::LED_ALARM_SET] = 1'b0;
                    hour_channel_q = !hour_channel_q;
                    if (hour_channel_q)
                        alarm_hour_q = scaled_hours(smp);
                    else
                        alarm_minute_q = scaled_minutes(smp);
                    if (held_edge(a_press)) begin
                        leds_q[acmc_pkg::LED_ALARM_SET] = 1'b1;
                        mode_q = MODE_RUN;
                    end
                end
                default: begin
                    leds_q[acmc_pkg::LED_RING] = 1'b0;
                    if (held_edge(s_press)) begin
                        leds_q[acmc_pkg::LED_RING] = 1'b1;
                        armed_q = !armed_q;
                        mode_q  = MODE_RUN;
                    end
                end
            endcase
        end

        r.hours         = hour_q;
        r.minutes       = minute_q;
        r.seconds       = second_q;
        r.alarm_hours   = alarm_hour_q;
        r.alarm_minutes = alarm_minute_q;
        r.mode          = mode_q;
        r.alarm_enabled = armed_q;
        r.ring_led      = leds_q[acmc_pkg::LED_RING];
        r.time_set_led  = leds_q[acmc_pkg::LED_TIME_SET];
        r.alarm_set_led = leds_q[acmc_pkg::LED_ALARM_SET];
        r.step_done     = step;
        return r;
    endfunction

    function automatic string describe(clock_result_t r);
        return {$sformatf("%02d:%02d:%02d alarm %02d:%02d",
                          r.hours, r.minutes, r.seconds, r.alarm_hours, r.alarm_minutes),
                $sformatf(" mode %0d en %0b ring %0b tset %0b aset %0b step %0b",
                          r.mode, r.alarm_enabled, r.ring_led, r.time_set_led,
                          r.alarm_set_led, r.step_done)};
    endfunction

    // ------------------------------------------------------------------------
    // monitor: config mirror, prediction on each input transaction and the
    // comparison of each result transaction, all on pre-edge values
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        clock_result_t got;
        if (!aresetn) begin
            reset_clock_mirror();
            clock_results_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == acmc_pkg::REG_PERIODS_PER_STEP)
                    steps_cfg = cfg_wdata;
                else if (cfg_addr == acmc_pkg::REG_PRESS_LIMIT)
                    limit_cfg = cfg_wdata[2:0];
            end
            if (s_valid && s_ready)
                clock_results_q.push_back(advance_period(s_set_time_pressed,
                    s_set_alarm_pressed, s_snooze_pressed, s_adc_sample));
            if (m_valid && m_ready) begin
                got = {m_hours, m_minutes, m_seconds, m_alarm_hours, m_alarm_minutes,
                       m_mode, m_alarm_enabled, m_ring_led, m_time_set_led,
                       m_alarm_set_led, m_step_done};
                if (clock_results_q.size() == 0) begin
                    if (n_mismatch < 10)
                        $display("unexpected result transaction: %s", describe(got));
                    n_mismatch++;
                end else begin
                    if (got !== clock_results_q[0]) begin
                        if (n_mismatch < 10)
                            $display("mismatch\n  expected %s\n  actual   %s",
                                     describe(clock_results_q[0]), describe(got));
                        n_mismatch++;
                    end
                    void'(clock_results_q.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver back-pressure: a pattern that runs through four modes in turn as rx_cycle counts cycles
    // ------------------------------------------------------------------------
    int rx_cycle = 0;

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 256) % 4)
            0:       m_ready <= 1'b1;                      // no stalls
            1:       m_ready <= $urandom_range(0, 1) == 0; // coin toss
            2:       m_ready <= $urandom_range(0, 3) != 0; // mostly ready
            default: m_ready <= (rx_cycle % 7) < 3;        // fixed duty pattern
        endcase
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles in a row with no transaction on either channel
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
            $display("tb_alarm_clock_mode_controller NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sender side helpers
    // ------------------------------------------------------------------------

    // one timer period; bursts of random length with random gaps in between
    task automatic send_period(input logic t, input logic a, input logic s,
                               input logic [9:0] smp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (quiet_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid             <= 1'b1;
        s_set_time_pressed  <= t;
        s_set_alarm_pressed <= a;
        s_snooze_pressed    <= s;
        s_adc_sample        <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    // n periods with one button held, a negative sample means random
    task automatic press_periods(input button_t btn, input int n, input int smp);
        logic [9:0] v;
        repeat (n) begin
            v = (smp < 0) ? 10'($urandom_range(0, 1023)) : 10'(smp);
            send_period(btn == BTN_TIME, btn == BTN_ALARM, btn == BTN_SNOOZE, v);
        end
    endtask

    // hold everything back until every result is in
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (clock_results_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        burst_left = 0;
    endtask

    // both registers in back-to-back write cycles, only while idle
    task automatic write_cfg(input logic [3:0] steps, input logic [3:0] limit_word);
        cfg_we    <= 1'b1;
        cfg_addr  <= acmc_pkg::REG_PERIODS_PER_STEP;
        cfg_wdata <= steps;
        @(posedge aclk);
        cfg_addr  <= acmc_pkg::REG_PRESS_LIMIT;
        cfg_wdata <= limit_word;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic int step_periods();
        return (steps_cfg == 0) ? 1 : int'(steps_cfg);
    endfunction

    // enter a set mode, load a few samples, leave on a fresh press
    task automatic set_sequence(input button_t btn, input int smp);
        int p;
        int l;
        p = step_periods();
        l = (limit_cfg == 0) ? 1 : int'(limit_cfg);
        press_periods(btn, l + $urandom_range(0, 1), smp);
        press_periods(BTN_NONE, 2 * p + 1 + $urandom_range(0, 2 * p), smp);
        press_periods(btn, p, smp);
        press_periods(BTN_NONE, 1, smp);
    endtask

    // release long enough for a step, then press through a step
    task automatic snooze_tap();
        press_periods(BTN_NONE, step_periods(), -1);
        press_periods(BTN_SNOOZE, step_periods(), -1);
        press_periods(BTN_NONE, 1, -1);
    endtask

    // one sample gives time and alarm the same hh:mm, then arm and wait
    task automatic ring_sequence();
        int smp;
        smp = $urandom_range(0, 1023);
        drain_results();
        set_sequence(BTN_TIME, smp);
        set_sequence(BTN_ALARM, smp);
        // sender pauses here until the clock mirror is settled
        drain_results();
        if (!armed_q)
            snooze_tap();
        press_periods(BTN_NONE, 3 * step_periods() + 1, smp);
        snooze_tap();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset state and default config, sample extremes with no buttons
    task automatic test_power_on_run();
        send_period(1'b0, 1'b0, 1'b0, 10'd0);
        send_period(1'b0, 1'b0, 1'b0, 10'd1023);
    endtask

    // enter time setting, load 23 then 59, leave with a fresh press
    task automatic test_time_setting();
        press_periods(BTN_TIME, 4, 0);
        press_periods(BTN_NONE, 2, 1023);
        press_periods(BTN_TIME, 1, 0);
    endtask

    // alarm to the current hh:mm, then arm it; the first snooze press meets the held flag, the second arms
    task automatic test_alarm_ring();
        press_periods(BTN_ALARM, 4, 0);
        press_periods(BTN_NONE, 1, 1023);
        press_periods(BTN_NONE, 1, 0);
        press_periods(BTN_ALARM, 1, 1023);
        press_periods(BTN_SNOOZE, 1, 0);
        press_periods(BTN_NONE, 2, 0);
        press_periods(BTN_SNOOZE, 1, 0);
    endtask

    // both set buttons together while the alarm armed before starts ringing, which freezes the press counters
    task automatic test_both_buttons();
        repeat (5) send_period(1'b1, 1'b1, 1'b0, 10'd512);
    endtask

    // zero registers: every period a step; a snooze ends the ringing, then time setting on every period
    task automatic test_zero_registers();
        send_period(1'b0, 1'b1, 1'b1, 10'd1023);
        send_period(1'b1, 1'b1, 1'b0, 10'd0);
        send_period(1'b0, 1'b0, 1'b1, 10'd341);
    endtask

    // random phases over several settings, extremes among them
    task automatic test_random_operation();
        logic [3:0] steps_list [8] = '{4'd1, 4'd2, 4'd3, 4'd15, 4'd0, 4'd1, 4'd7, 4'd2};
        logic [2:0] limit_list [8] = '{3'd4, 3'd7, 3'd1, 3'd7, 3'd0, 3'd2, 3'd5, 3'd3};
        int start;
        for (int ph = 0; ph < 8; ph++) begin
            drain_results();
            // bit 3 of the limit write is outside the register
            write_cfg(steps_list[ph], {1'($urandom_range(0, 1)), limit_list[ph]});
            quiet_sender = (ph % 3 == 1);
            start = n_sent;
            while (n_sent - start < PHASE_PERIODS) begin
                case ($urandom_range(0, 11))
                    0, 1, 2: press_periods(BTN_NONE, $urandom_range(1, 8), -1);
                    3, 4:    set_sequence(BTN_TIME, -1);
                    5, 6:    set_sequence(BTN_ALARM, -1);
                    7, 8:    snooze_tap();
                    9:       ring_sequence();
                    default: begin
                        // broken sequences: random button levels
                        repeat ($urandom_range(1, 6))
                            send_period(1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)),
                                        10'($urandom_range(0, 1023)));
                    end
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_power_on_run();
        drain_results();
        write_cfg(4'd1, 4'd4);
        test_time_setting();
        test_alarm_ring();
        test_both_buttons();
        drain_results();
        write_cfg(4'd0, 4'd0);
        test_zero_registers();
        test_random_operation();

        drain_results();
        repeat (5) @(posedge aclk);
        // any expectation still waiting is a failure
        if (clock_results_q.size() != 0)
            n_mismatch++;
        if (n_mismatch == 0) begin
            $display("tb_alarm_clock_mode_controller OK");
        end else begin
            $display("tb_alarm_clock_mode_controller NOT OK");
        end
        $finish;
    end

endmodule
